@@ hw/rtl/linear_probe_hash_table_macros.svh @@
// Assertion macros for the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LPHT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ hw/rtl/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probing hash table modules.
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;
   localparam int SLOTS     = 16;
   localparam int KEY_CHARS = 8;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int KEY_W     = 64;
   localparam int LEN_W     = 4;
   localparam int VAL_W     = 32;
   localparam int ENTRY_W   = KEY_W + LEN_W + VAL_W;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [VAL_W-1:0] value;
   } entry_type;
endpackage
`default_nettype wire

@@ hw/rtl/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

@@ hw/rtl/lpht_hash.sv @@
// ----------------------------------------------------------------------------
// lpht_hash
// Serial polynomial hash, one character at a time: h = (h*31 + c) mod n.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_hash (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lpht_pkg::KEY_W-1:0]    key,
   input  wire logic [lpht_pkg::LEN_W-1:0]    len,
   input  wire logic [lpht_pkg::CNT_W-1:0]    size,
   output logic                               done,
   output logic      [lpht_pkg::IDX_W-1:0]    home
);
   import lpht_pkg::*;

   localparam int PROD_W = CNT_W + 13;

   logic               busy_ff, busy_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [PROD_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]   h_ff, h_in;
   logic [3:0]         sub_ff, sub_in;
   logic               done_ff, done_in;

   // Each character: form h*31+c (below 512*n), then reduce by one
   // conditional subtract of n<<k per cycle, for k from 8 down to 0.
   always_comb begin
      logic [PROD_W-1:0] shifted;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      key_in  = key_ff;
      rem_in  = rem_ff;
      h_in    = h_ff;
      sub_in  = sub_ff;
      done_in = 1'b0;
      shifted = PROD_W'(size) << sub_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = len;
         key_in  = key;
         h_in    = '0;
         sub_in  = 4'd0;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (sub_ff == 4'd0) begin
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               rem_in = (PROD_W'(h_ff) << 5) - PROD_W'(h_ff) + PROD_W'(key_ff[7:0]);
               key_in = key_ff >> 8;
               cnt_in = cnt_ff - 1'b1;
               sub_in = 4'd9;
            end
         end else begin
            shifted = PROD_W'(size) << (sub_ff - 4'd1);
            if (rem_ff >= shifted) begin
               rem_in = rem_ff - shifted;
            end
            sub_in = sub_ff - 4'd1;
            if (sub_ff == 4'd1) begin
               h_in = (rem_ff >= shifted) ? IDX_W'(rem_ff - shifted) : IDX_W'(rem_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sub_ff  <= 4'd0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         sub_ff  <= sub_in;
         cnt_ff  <= cnt_in;
      end
      key_ff <= key_in;
      rem_ff <= rem_in;
      h_ff   <= h_in;
   end

   assign done = done_ff;
   assign home = h_ff;
endmodule
`default_nettype wire

@@ hw/rtl/linear_probe_hash_table.sv @@
// Sequence: the key is hashed one character at a time, slots are probed from
// its home slot, then the response word is sent; a delete rehashes and
// reinserts each following cluster entry, then stops at the cluster's end.
// Throughput: one word at a time; req_tready is low until the result leaves.
// Reset: synchronous, active high; clears all slot-used bits and sets the
// table size to 16. Slot contents live in a RAM and are not cleared.
`default_nettype none
module linear_probe_hash_table (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [4:0]   csr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: op[1:0], key_chars[65:2], key_length[69:66], value[101:70]
   input  wire logic [103:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: status[1:0], found_value[33:2]
   output logic [39:0]       rsp_tdata
);
   import lpht_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_HASH_GO, S_HASH, S_PROBE, S_CHECK, S_DEL_NEXT, S_DEL_READ,
      S_DEL_HASH_GO, S_DEL_HASH, S_RE_PROBE, S_RE_CHECK, S_DEL_STEP, S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         size_ff, size_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [1:0]         op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   nx_ff, nx_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   dk_ff, dk_in;
   entry_type          mv_ff, mv_in;
   logic [1:0]         st_ff, st_in;
   logic [VAL_W-1:0]   fv_ff, fv_in;

   logic [CNT_W-1:0]   n;
   logic               h_start, h_done;
   logic [IDX_W-1:0]   h_home;
   logic [KEY_W-1:0]   h_key;
   logic [LEN_W-1:0]   h_len;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_addr;
   entry_type          ram_wd, ram_rd;
   logic [LEN_W-1:0]   in_len;
   logic [KEY_W-1:0]   in_mask;

   assign n = (size_ff == 5'd0) ? CNT_W'(1) :
              (32'(size_ff) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(size_ff);

   function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] i, logic [CNT_W-1:0] m);
      logic [CNT_W-1:0] t;
      t = CNT_W'(i) + CNT_W'(1);
      return (t >= m) ? '0 : IDX_W'(t);
   endfunction

   assign in_len  = (req_tdata[69:66] > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS) : req_tdata[69:66];
   assign in_mask = (in_len >= 4'd8) ? '1 : ((KEY_W'(1) << {in_len, 3'b000}) - KEY_W'(1));

   lpht_hash u_hash (
      .clock (clock), .reset (reset), .start (h_start), .key (h_key), .len (h_len),
      .size (n), .done (h_done), .home (h_home)
   );

   lpht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
      .clock (clock), .wr_en (ram_we), .addr (ram_addr), .wr_data (ram_wd), .rd_data (ram_rd)
   );

   always_comb begin
      logic hit;
      state_in = state_ff;
      size_in  = size_ff;
      used_in  = used_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      len_in   = len_ff;
      val_in   = val_ff;
      idx_in   = idx_ff;
      nx_in    = nx_ff;
      k_in     = k_ff;
      dk_in    = dk_ff;
      mv_in    = mv_ff;
      st_in    = st_ff;
      fv_in    = fv_ff;
      h_start  = 1'b0;
      h_key    = key_ff;
      h_len    = len_ff;
      ram_we   = 1'b0;
      ram_addr = idx_ff;
      ram_wd   = '{key: key_ff, len: len_ff, value: val_ff};
      hit      = used_ff[idx_ff] && ram_rd.len == len_ff && ram_rd.key == key_ff;
      if (csr_valid && state_ff == S_IDLE) begin
         size_in = csr_data;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !csr_valid) begin
               op_in  = req_tdata[1:0];
               key_in = req_tdata[65:2] & in_mask;
               len_in = in_len;
               val_in = req_tdata[101:70];
               st_in  = ST_OK;
               fv_in  = '0;
               state_in = (req_tdata[1:0] == OP_NONE) ? S_RESP : S_HASH_GO;
            end
         end
         S_HASH_GO: begin
            h_start  = 1'b1;
            state_in = S_HASH;
         end
         S_HASH: begin
            if (h_done) begin
               idx_in   = h_home;
               k_in     = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (k_ff >= n) begin
               st_in    = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
               state_in = S_RESP;
            end else if (!used_ff[idx_ff] && op_ff != OP_INSERT) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (op_ff == OP_INSERT) begin
               if (!used_ff[idx_ff] || hit) begin
                  ram_we = 1'b1;
                  used_in[idx_ff] = 1'b1;
                  state_in = S_RESP;
               end
            end else if (hit) begin
               if (op_ff == OP_SEARCH) begin
                  fv_in    = ram_rd.value;
                  state_in = S_RESP;
               end else begin
                  used_in[idx_ff] = 1'b0;
                  nx_in    = wrap_inc(idx_ff, n);
                  dk_in    = CNT_W'(1);
                  state_in = S_DEL_NEXT;
               end
            end
            if (state_in == S_CHECK) begin
               idx_in   = wrap_inc(idx_ff, n);
               k_in     = k_ff + CNT_W'(1);
               state_in = S_PROBE;
            end
         end
         S_DEL_NEXT: begin
            ram_addr = nx_ff;
            if (dk_ff >= n || !used_ff[nx_ff]) begin
               state_in = S_RESP;
            end else begin
               used_in[nx_ff] = 1'b0;
               state_in = S_DEL_READ;
            end
         end
         S_DEL_READ: begin
            mv_in    = ram_rd;
            state_in = S_DEL_HASH_GO;
         end
         S_DEL_HASH_GO: begin
            h_start  = 1'b1;
            h_key    = mv_ff.key;
            h_len    = mv_ff.len;
            state_in = S_DEL_HASH;
         end
         S_DEL_HASH: begin
            if (h_done) begin
               idx_in   = h_home;
               k_in     = '0;
               state_in = S_RE_PROBE;
            end
         end
         S_RE_PROBE: begin
            state_in = (k_ff >= n) ? S_DEL_STEP : S_RE_CHECK;
         end
         S_RE_CHECK: begin
            if (!used_ff[idx_ff] ||
                (ram_rd.len == mv_ff.len && ram_rd.key == mv_ff.key)) begin
               ram_we = 1'b1;
               ram_wd = mv_ff;
               used_in[idx_ff] = 1'b1;
               state_in = S_DEL_STEP;
            end else begin
               idx_in   = wrap_inc(idx_ff, n);
               k_in     = k_ff + CNT_W'(1);
               state_in = S_RE_PROBE;
            end
         end
         S_DEL_STEP: begin
            nx_in    = wrap_inc(nx_ff, n);
            dk_in    = dk_ff + CNT_W'(1);
            state_in = S_DEL_NEXT;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= 5'd16;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         used_ff  <= used_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
      len_ff <= len_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      nx_ff  <= nx_in;
      k_ff   <= k_in;
      dk_ff  <= dk_in;
      mv_ff  <= mv_in;
      st_ff  <= st_in;
      fv_ff  <= fv_in;
   end

   assign csr_ready  = (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {6'd0, fv_ff, st_ff};
endmodule
`default_nettype wire

@@ hw/rtl/lpht_checker.sv @@
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table handshakes and results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_probe_hash_table_macros.svh"
module lpht_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [39:0]  rsp_tdata
);
   import lpht_pkg::*;

   `LPHT_ASSERT_IMP(a_no_req_while_rsp, clock, reset, rsp_tvalid, !req_tready)
   `LPHT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `LPHT_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[1:0] <= ST_FULL)
   `LPHT_ASSERT_IMP(a_value_zero_on_miss, clock, reset, rsp_tvalid && rsp_tdata[1:0] != ST_OK,
      rsp_tdata[33:2] == 32'd0)
   `LPHT_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock (clock), .reset (reset),
   .req_tvalid (req_tvalid), .req_tready (req_tready), .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready), .rsp_tdata (rsp_tdata)
);
`default_nettype wire

@@ sim/tb_linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// Testbench for linear_probe_hash_table
// Drives insert, search, delete and no-op words through the request stream
// and keeps a shadow copy of the table to predict each response. The bench
// compares status and found value of each response to the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_linear_probe_hash_table;
   import lpht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
   } answer_type;

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic [4:0]   csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;

   linear_probe_hash_table i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   logic            used_m [SLOTS];
   logic [63:0]     key_m  [SLOTS];
   logic [3:0]      len_m  [SLOTS];
   logic [31:0]     val_m  [SLOTS];
   logic [4:0]      size_reg;
   answer_type      pending_answers[$];
   int              mismatches;
   int              idle_cycles;
   bit              hold_rsp;
   logic [63:0]     key_pool[8];
   logic [3:0]      len_pool[8];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int active_slots();
      if (size_reg == 0) return 1;
      if (size_reg > SLOTS) return SLOTS;
      return size_reg;
   endfunction

   function automatic int hash_home(logic [63:0] k, int l, int n);
      int h;
      h = 0;
      for (int i = 0; i < l; i++) h = (h * 31 + k[8*i +: 8]) % n;
      return h;
   endfunction

   function automatic bit table_store(logic [63:0] k, logic [3:0] l, logic [31:0] v, int n);
      int idx;
      idx = hash_home(k, l, n);
      for (int p = 0; p < n; p++) begin
         if (!used_m[idx] || (len_m[idx] == l && key_m[idx] == k)) begin
            used_m[idx] = 1'b1; key_m[idx] = k; len_m[idx] = l; val_m[idx] = v;
            return 1'b1;
         end
         idx = (idx + 1) % n;
      end
      return 1'b0;
   endfunction

   function automatic int table_find(logic [63:0] k, logic [3:0] l, int n);
      int idx;
      idx = hash_home(k, l, n);
      for (int p = 0; p < n && used_m[idx]; p++) begin
         if (len_m[idx] == l && key_m[idx] == k) return idx;
         idx = (idx + 1) % n;
      end
      return n;
   endfunction

   function automatic answer_type table_apply(logic [1:0] op, logic [63:0] kc, logic [3:0] kl,
                                              logic [31:0] v);
      answer_type a;
      int n, l, s, nx;
      logic [63:0] k;
      n = active_slots();
      l = (kl > KEY_CHARS) ? KEY_CHARS : kl;
      k = kc;
      for (int i = l; i < 8; i++) k[8*i +: 8] = 8'h00;
      a = '0;
      if (op == OP_INSERT) begin
         if (!table_store(k, 4'(l), v, n)) a.status = ST_FULL;
      end else if (op == OP_SEARCH) begin
         s = table_find(k, 4'(l), n);
         if (s < n) a.value = val_m[s];
         else a.status = ST_NOT_FOUND;
      end else if (op == OP_DELETE) begin
         s = table_find(k, 4'(l), n);
         if (s < n) begin
            used_m[s] = 1'b0;
            nx = (s + 1) % n;
            for (int c = 1; c < n && used_m[nx]; c++) begin
               used_m[nx] = 1'b0;
               void'(table_store(key_m[nx], len_m[nx], val_m[nx], n));
               nx = (nx + 1) % n;
            end
         end else a.status = ST_NOT_FOUND;
      end
      return a;
   endfunction

   task automatic send_word(logic [1:0] op, logic [63:0] kc, logic [3:0] kl, logic [31:0] v);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) gap = 1;
      repeat (gap) @(posedge clock);
      req_tdata  <= {2'b00, v, kl, kc, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_answers.push_back(table_apply(op, kc, kl, v));
      req_tvalid <= 1'b0;
   endtask

   task automatic write_size(logic [4:0] sz);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_data  <= sz;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      size_reg = sz;
   endtask

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_directed();
      send_word(OP_SEARCH, 64'h0, 4'd0, 32'h0);
      send_word(OP_INSERT, 64'h0, 4'd0, 32'h8000_0000);
      send_word(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, 32'h0);
      send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h7FFF_FFFF);
      send_word(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0);
      send_word(OP_INSERT, 64'h00AA_0000_0000_0061, 4'd1, 32'hFFFF_FFFF);
      send_word(OP_SEARCH, 64'h61, 4'd1, 32'h1234);
      send_word(OP_INSERT, 64'h61, 4'd1, 32'h5555_AAAA);
      send_word(OP_SEARCH, 64'h61, 4'd2, 32'h0);
      send_word(OP_DELETE, 64'h61, 4'd1, 32'h0);
      send_word(OP_DELETE, 64'h61, 4'd1, 32'h0);
      send_word(OP_NONE, 64'h62, 4'd1, 32'h1);
      send_word(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
   endtask

   task automatic test_size(logic [4:0] sz, int count);
      int pick;
      write_size(sz);
      for (int i = 0; i < 8; i++) begin
         key_pool[i] = rand_key();
         len_pool[i] = 4'($urandom_range(0, 9));
         if ($urandom_range(0, 1)) key_pool[i] = key_pool[i] & 64'h0303_0303_0303_0303;
      end
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 7);
         if ($urandom_range(0, 9) == 0)
            send_word(2'($urandom_range(0, 3)), rand_key(), 4'($urandom_range(0, 15)),
                      $urandom());
         else
            send_word(2'($urandom_range(0, 2)), key_pool[pick], len_pool[pick], $urandom());
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) send_word(OP_INSERT, rand_key(), 4'd3, $urandom());
   endtask

   initial begin
      reset = 1'b1; csr_valid = 1'b0; csr_data = '0;
      req_tvalid = 1'b0; req_tdata = '0; rsp_tready = 1'b0;
      mismatches = 0; hold_rsp = 1'b0; size_reg = 5'd16;
      for (int i = 0; i < SLOTS; i++) used_m[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_size(5'd16, 150);
      test_size(5'd1, 60);
      test_size(5'd0, 40);
      test_size(5'd31, 100);
      test_size(5'd3, 120);
      test_size(5'd5, 120);
      test_size(5'd9, 150);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatches == 0) $display("tb_linear_probe_hash_table: done, clean");
      else $display("tb_linear_probe_hash_table: done, errors");
      $finish;
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp && hold == 0) hold = 300;
         if (hold > 0) begin
            hold--;
            if (hold == 0) hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
         end else rsp_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[1:0] !== want.status || rsp_tdata[33:2] !== want.value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d value %h, got status %0d value %h",
                           want.status, want.value, rsp_tdata[1:0], rsp_tdata[33:2]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb_linear_probe_hash_table: done, errors");
         $finish;
      end
   end
endmodule
`default_nettype wire
